@@ rtl/csirs_ltd_pkg.sv @@
// types, constants and the row table for the csi-rs location table decoder
// depends on nothing; used by csi_rs_location_table_decoder
`timescale 1ns / 1ps

package csirs_ltd_pkg;

   localparam int BitmapWidth = 12;
   localparam int PosCount    = 6;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_ROW  = 2'd1;
   localparam logic [1:0] STATUS_FEW_BITS = 2'd2;

   typedef struct packed {
      logic [4:0]  table_row;
      logic [11:0] freq_bitmap;
      logic [3:0]  first_symbol;
      logic [3:0]  second_symbol;
   } req_word_type;

   typedef struct packed {
      logic [3:0] group_port_index;
      logic [5:0] subcarrier_offset;
      logic [3:0] symbol_offset;
      logic [5:0] port_count;
      logic       k_prime_max;
      logic [1:0] l_prime_max;
      logic [1:0] status;
      logic       last_group;
   } rsp_word_type;

   // which bitmap position a group uses
   typedef enum logic [2:0] {
      KIDX_ZERO,
      KIDX_GROUP,
      KIDX_MOD2,
      KIDX_MOD3,
      KIDX_MOD4
   } kidx_mode_type;

   // extra subcarrier step per group
   typedef enum logic [1:0] {
      KADD_NONE,
      KADD_X2,
      KADD_X4
   } kadd_mode_type;

   // how the symbol offset follows the group index
   typedef enum logic [2:0] {
      LBAR_FIXED,
      LBAR_STEP1,
      LBAR_STEP2,
      LBAR_STEP4,
      LBAR_SPLIT6,
      LBAR_SPLIT3,
      LBAR_SPLIT8,
      LBAR_SPLIT4
   } lbar_mode_type;

   typedef struct packed {
      logic          valid;
      logic [5:0]    ports;
      logic          kmax;
      logic [1:0]    lmax;
      logic [4:0]    groups;
      logic [3:0]    need;
      logic [1:0]    shift;
      logic          j_zero;
      kidx_mode_type kidx_mode;
      kadd_mode_type kadd_mode;
      lbar_mode_type lbar_mode;
   } row_desc_type;

   function automatic row_desc_type row_desc(input logic [4:0] row);
      row_desc_type d;
      d = '{valid: 1'b1, ports: 6'd0, kmax: 1'b1, lmax: 2'd0, groups: 5'd0, need: 4'd0,
            shift: 2'd1, j_zero: 1'b0, kidx_mode: KIDX_GROUP, kadd_mode: KADD_NONE,
            lbar_mode: LBAR_FIXED};
      unique case (row)
         5'd1: begin
            d.ports = 6'd1; d.kmax = 1'b0; d.groups = 5'd3; d.need = 4'd1;
            d.shift = 2'd0; d.j_zero = 1'b1; d.kidx_mode = KIDX_ZERO;
            d.kadd_mode = KADD_X4;
         end
         5'd2: begin
            d.ports = 6'd1; d.kmax = 1'b0; d.groups = 5'd1; d.need = 4'd1;
            d.shift = 2'd0; d.j_zero = 1'b1; d.kidx_mode = KIDX_ZERO;
         end
         5'd3: begin
            d.ports = 6'd2; d.groups = 5'd1; d.need = 4'd1;
            d.j_zero = 1'b1; d.kidx_mode = KIDX_ZERO;
         end
         5'd4: begin
            d.ports = 6'd4; d.groups = 5'd2; d.need = 4'd1; d.shift = 2'd2;
            d.kidx_mode = KIDX_ZERO; d.kadd_mode = KADD_X2;
         end
         5'd5: begin
            d.ports = 6'd4; d.groups = 5'd2; d.need = 4'd1;
            d.kidx_mode = KIDX_ZERO; d.lbar_mode = LBAR_STEP1;
         end
         5'd6: begin
            d.ports = 6'd8; d.groups = 5'd4; d.need = 4'd4;
         end
         5'd7: begin
            d.ports = 6'd8; d.groups = 5'd4; d.need = 4'd2;
            d.kidx_mode = KIDX_MOD2; d.lbar_mode = LBAR_STEP2;
         end
         5'd8: begin
            d.ports = 6'd8; d.lmax = 2'd1; d.groups = 5'd2; d.need = 4'd2;
         end
         5'd9: begin
            d.ports = 6'd12; d.groups = 5'd6; d.need = 4'd6;
         end
         5'd10: begin
            d.ports = 6'd12; d.lmax = 2'd1; d.groups = 5'd3; d.need = 4'd3;
         end
         5'd11: begin
            d.ports = 6'd16; d.groups = 5'd8; d.need = 4'd4;
            d.kidx_mode = KIDX_MOD4; d.lbar_mode = LBAR_STEP4;
         end
         5'd12: begin
            d.ports = 6'd16; d.lmax = 2'd1; d.groups = 5'd4; d.need = 4'd4;
         end
         5'd13: begin
            d.ports = 6'd24; d.groups = 5'd12; d.need = 4'd3;
            d.kidx_mode = KIDX_MOD3; d.lbar_mode = LBAR_SPLIT6;
         end
         5'd14: begin
            d.ports = 6'd24; d.lmax = 2'd1; d.groups = 5'd6; d.need = 4'd3;
            d.kidx_mode = KIDX_MOD3; d.lbar_mode = LBAR_SPLIT3;
         end
         5'd15: begin
            d.ports = 6'd24; d.lmax = 2'd3; d.groups = 5'd3; d.need = 4'd3;
         end
         5'd16: begin
            d.ports = 6'd32; d.groups = 5'd16; d.need = 4'd4;
            d.kidx_mode = KIDX_MOD4; d.lbar_mode = LBAR_SPLIT8;
         end
         5'd17: begin
            d.ports = 6'd32; d.lmax = 2'd1; d.groups = 5'd8; d.need = 4'd4;
            d.kidx_mode = KIDX_MOD4; d.lbar_mode = LBAR_SPLIT4;
         end
         5'd18: begin
            d.ports = 6'd32; d.lmax = 2'd3; d.groups = 5'd4; d.need = 4'd4;
         end
         default: begin
            d.valid = 1'b0;
         end
      endcase
      return d;
   endfunction

endpackage

@@ rtl/csi_rs_location_table_decoder.sv @@
// csi-rs location table decoder: one word in, one result word per cdm group out (one on error)
// depends on csirs_ltd_pkg
`timescale 1ns / 1ps

//  channel | ports                              | carries
//  --------+------------------------------------+------------------------------------
//  in      | req_valid, req_ready, req_word     | row, bitmap, l0, l1
//  out     | rsp_valid, rsp_ready, rsp_word     | one cdm group result, last on final
//
//  an accepted word sits in the item register; the group counter then walks the
//  row's cdm groups, one result per cycle into the result register unless it stalls
//  a word gives 1 to 16 results (one per group, one for an error result); the
//  group counter sets that figure, and the next word is taken in the cycle the
//  final group is produced, so words follow with no gap
//  a stalled result holds the result register and the counter; reset clears
//  only the valid flags and the counter

module csi_rs_location_table_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  csirs_ltd_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output csirs_ltd_pkg::rsp_word_type rsp_word
);

   import csirs_ltd_pkg::*;

   // item register and group counter
   logic         item_valid_ff, item_valid_in;
   req_word_type item_ff, item_in;
   logic [3:0]   grp_ff, grp_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   row_desc_type desc;
   logic [3:0]   pos [PosCount];
   logic [3:0]   bit_total;
   logic [1:0]   status_s;
   logic [4:0]   n_results;
   logic         last_s;
   logic         advance;
   logic [2:0]   kidx;
   logic [3:0]   pos_sel;
   logic [5:0]   kbar;
   logic [5:0]   kadd;
   logic [3:0]   lbar;
   logic [3:0]   l0, l1;
   rsp_word_type result;

   assign desc = row_desc(item_ff.table_row);
   assign l0   = item_ff.first_symbol;
   assign l1   = item_ff.second_symbol;

   // positions of the lowest set bitmap bits, plus the total set count
   always_comb begin
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int p = 0; p < PosCount; p++) begin
         pos[p] = 4'd0;
      end
      for (int f = 0; f < BitmapWidth; f++) begin
         if (item_ff.freq_bitmap[f]) begin
            if (cnt < 4'(PosCount)) begin
               pos[cnt[2:0]] = 4'(f);
            end
            cnt = cnt + 4'd1;
         end
      end
      bit_total = cnt;
   end

   // invalid row is checked before the bitmap
   always_comb begin
      priority if (!desc.valid) begin
         status_s = STATUS_BAD_ROW;
      end else if (bit_total < desc.need) begin
         status_s = STATUS_FEW_BITS;
      end else begin
         status_s = STATUS_OK;
      end
   end

   assign n_results = (status_s == STATUS_OK) ? desc.groups : 5'd1;
   assign last_s    = ({1'b0, grp_ff} + 5'd1) == n_results;

   // bitmap position used by this group
   always_comb begin
      unique case (desc.kidx_mode)
         KIDX_ZERO:  kidx = 3'd0;
         KIDX_GROUP: kidx = (grp_ff > 4'd5) ? 3'd5 : grp_ff[2:0];
         KIDX_MOD2:  kidx = {2'b00, grp_ff[0]};
         KIDX_MOD4:  kidx = {1'b0, grp_ff[1:0]};
         KIDX_MOD3: begin
            priority if (grp_ff >= 4'd9) begin
               kidx = 3'(grp_ff - 4'd9);
            end else if (grp_ff >= 4'd6) begin
               kidx = 3'(grp_ff - 4'd6);
            end else if (grp_ff >= 4'd3) begin
               kidx = 3'(grp_ff - 4'd3);
            end else begin
               kidx = grp_ff[2:0];
            end
         end
         default:    kidx = 3'd0;
      endcase
   end

   always_comb begin
      unique case (desc.kadd_mode)
         KADD_X2:   kadd = {1'b0, grp_ff, 1'b0};
         KADD_X4:   kadd = {grp_ff, 2'b00};
         default:   kadd = 6'd0;
      endcase
   end

   assign pos_sel = pos[kidx];
   assign kbar    = ({2'b00, pos_sel} << desc.shift) + kadd;

   // symbol offset, 4-bit wrap
   always_comb begin
      unique case (desc.lbar_mode)
         LBAR_FIXED:  lbar = l0;
         LBAR_STEP1:  lbar = l0 + grp_ff;
         LBAR_STEP2:  lbar = l0 + {1'b0, grp_ff[3:1]};
         LBAR_STEP4:  lbar = l0 + {2'b00, grp_ff[3:2]};
         LBAR_SPLIT6: lbar = (grp_ff < 4'd6) ? l0 + {3'b000, grp_ff >= 4'd3}
                                             : l1 + {3'b000, grp_ff >= 4'd9};
         LBAR_SPLIT3: lbar = (grp_ff < 4'd3) ? l0 : l1;
         LBAR_SPLIT8: lbar = (grp_ff < 4'd8) ? l0 + {3'b000, grp_ff[2]}
                                             : l1 + {3'b000, grp_ff >= 4'd12};
         LBAR_SPLIT4: lbar = (grp_ff < 4'd4) ? l0 : l1;
         default:     lbar = l0;
      endcase
   end

   always_comb begin
      result = '0;
      if (status_s == STATUS_OK) begin
         result.group_port_index  = desc.j_zero ? 4'd0 : grp_ff;
         result.subcarrier_offset = kbar;
         result.symbol_offset     = lbar;
         result.port_count        = desc.ports;
         result.k_prime_max       = desc.kmax;
         result.l_prime_max       = desc.lmax;
      end
      result.status     = status_s;
      result.last_group = last_s;
   end

   // a group moves into the result register when that register is free or drains
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || (advance && last_s);

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      grp_in        = grp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
         if (last_s) begin
            item_valid_in = 1'b0;
         end else begin
            grp_in = grp_ff + 4'd1;
         end
      end
      if (req_valid && req_ready) begin
         item_in       = req_word;
         item_valid_in = 1'b1;
         grp_in        = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         grp_ff        <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         grp_ff        <= grp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // group counter stays inside the item's result count
   a_grp_in_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> ({1'b0, grp_ff} < n_results))
      else $error("group counter beyond result count");

   // a new word only lands on a busy item register when its final group leaves
   a_take_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && item_valid_ff) |-> (advance && last_s))
      else $error("word accepted while groups remain");

   // error results are single and final
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != STATUS_OK) |-> rsp_word.last_group)
      else $error("error result not marked last");

   // good results always carry a port count
   a_ok_ports: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STATUS_OK) |-> (rsp_word.port_count != 6'd0))
      else $error("good result without ports");

endmodule
